// ----- rtl/wci5_pkg.sv -----
// Package for the 5-D Ising Wolff cluster unit: item types, action codes,
// lattice constants and the xorshift32 step. No dependencies.
package wci5_pkg;

  localparam int SIDE_DEF = 4;

  localparam logic [1:0] ACT_WRITE   = 2'd0;
  localparam logic [1:0] ACT_READ    = 2'd1;
  localparam logic [1:0] ACT_CLUSTER = 2'd2;
  localparam logic [1:0] ACT_MEASURE = 2'd3;

  localparam logic CFG_THRESHOLD = 1'b0;
  localparam logic CFG_SEED      = 1'b1;

  typedef struct packed {
    logic [1:0] action;
    logic [1:0] coord_x;
    logic [1:0] coord_y;
    logic [1:0] coord_z;
    logic [1:0] coord_w;
    logic [1:0] coord_u;
    logic       spin_in;
  } in_item_t;

  typedef struct packed {
    logic              spin_out;
    logic [10:0]       cluster_size;
    logic signed [11:0] spin_sum;
    logic signed [14:0] bond_sum;
  } out_item_t;

  function automatic logic [31:0] xorshift32(input logic [31:0] s);
    logic [31:0] x;
    x = s ^ (s << 13);
    x = x ^ (x >> 17);
    x = x ^ (x << 5);
    return x;
  endfunction

endpackage

// ----- rtl/wolff_cluster_ising_5d_unit.sv -----
// Wolff cluster unit on a periodic 5-D Ising lattice of SIDE^5 one-bit spins.
// A cluster item pops each member and tests its ten neighbors, then replays
// the queue in a flip pass. All cost is set by the single spin memory port,
// which serves one access per cycle. One item at a time; busy is high
// meanwhile. Reset (rst, synchronous) sets the threshold 0 and the RNG 1,
// then a clearing pass over all 2^(5*CW) addresses, with busy high, sets
// all spins +1.
// Depends on wci5_pkg, wci5_rng, wci5_nbr.
module wolff_cluster_ising_5d_unit
  import wci5_pkg::*;
#(
  parameter int SIDE = SIDE_DEF,
  localparam int CW = (SIDE > 1) ? $clog2(SIDE) : 1,
  localparam int AW = 5 * CW,
  localparam int NS = 1 << AW
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  in_item_t    in_item,
  output logic        done,
  output out_item_t   out_item,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data
);

  // The address space is a power-of-two cube of CW-bit coordinates. For a
  // SIDE that is not a power of two, unused addresses are touched only by the clearing pass.

  localparam logic [3:0] ST_IDLE    = 4'd0;
  localparam logic [3:0] ST_CLEAR   = 4'd1;
  localparam logic [3:0] ST_RW      = 4'd2;
  localparam logic [3:0] ST_SEEDRD  = 4'd3;
  localparam logic [3:0] ST_POP     = 4'd4;
  localparam logic [3:0] ST_NBRRD   = 4'd5;
  localparam logic [3:0] ST_NBRTEST = 4'd6;
  localparam logic [3:0] ST_FLIPRD  = 4'd7;
  localparam logic [3:0] ST_FLIPWR  = 4'd8;
  localparam logic [3:0] ST_MSITE   = 4'd9;
  localparam logic [3:0] ST_MNBR    = 4'd10;
  localparam logic [3:0] ST_MACC    = 4'd11;
  localparam logic [3:0] ST_OUT     = 4'd12;
  localparam logic [3:0] ST_FIFORD  = 4'd13;

  logic [3:0] state;

  // Spin memory holds the spin in bit 0 and the in-cluster mark in bit 1.
  // After reset a clearing pass writes +1 unmarked to all NS addresses.
  logic [1:0]    mem [NS];
  logic [AW-1:0] mem_addr;
  logic          mem_we;
  logic [1:0]    mem_wdata;
  logic [1:0]    mem_q;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    mem_q <= mem[mem_addr];
  end

  // Frontier queue, also replayed for the flip pass. Head and tail return
  // to zero after every cluster, so the seed always lands in entry zero.
  logic [AW-1:0] fifo [NS];
  logic          fifo_we;
  logic [AW:0]   fifo_head;
  logic [AW:0]   fifo_tail;
  logic [AW-1:0] fifo_raddr;
  logic [AW-1:0] fifo_q;

  always_ff @(posedge clk) begin
    if (fifo_we) begin
      fifo[fifo_tail[AW-1:0]] <= mem_addr;
    end
    fifo_q <= fifo[fifo_raddr];
  end

  assign fifo_raddr = fifo_head[AW-1:0];

  logic [15:0] threshold;
  logic        rng_step;
  logic [15:0] draw_next;

  wci5_rng u_rng (
    .clk       (clk),
    .rst       (rst),
    .load      (cfg_valid && cfg_ready && cfg_index == CFG_SEED),
    .load_value(cfg_data),
    .step      (rng_step),
    .draw_next (draw_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= '0;
    end else if (cfg_valid && cfg_ready && cfg_index == CFG_THRESHOLD) begin
      threshold <= cfg_data[15:0];
    end
  end

  logic [AW-1:0] cur;
  logic [3:0]    dir;
  logic [AW-1:0] nbr;

  wci5_nbr #(.SIDE(SIDE)) u_nbr (
    .site(cur),
    .dir (dir),
    .nbr (nbr)
  );

  logic [AW:0]   count;      // clearing sweep and measure site counter
  logic [1:0]    act;
  logic          seed_spin;
  logic          site_spin;
  logic          wr_spin;
  logic signed [11:0] ssum;
  logic signed [14:0] bsum;
  out_item_t     res;

  // A 2-bit coordinate is below 4, so one conditional subtract wraps it
  // for any SIDE of 2 or more.
  function automatic logic [CW-1:0] cmod(input logic [1:0] v);
    logic [31:0] w;
    w = 32'(v);
    if (w >= 32'(SIDE)) begin
      w = w - 32'(SIDE);
    end
    return CW'(w);
  endfunction

  logic [AW-1:0] in_addr;
  always_comb begin
    in_addr = {cmod(in_item.coord_x), cmod(in_item.coord_y), cmod(in_item.coord_z),
               cmod(in_item.coord_w), cmod(in_item.coord_u)};
  end

  // Site walk for measure in real coordinates (skip unused addresses).
  logic site_ok;
  always_comb begin
    site_ok = 1'b1;
    for (int d = 0; d < 5; d++) begin
      if (32'(count[d * CW +: CW]) >= SIDE) begin
        site_ok = 1'b0;
      end
    end
  end

  assign busy      = (state != ST_IDLE);
  assign cfg_ready = (state == ST_IDLE);

  always_comb begin
    mem_addr  = cur;
    mem_we    = 1'b0;
    mem_wdata = 2'b01;
    fifo_we   = 1'b0;
    rng_step  = 1'b0;
    case (state)
      ST_CLEAR: begin
        mem_addr = count[AW-1:0];
        mem_we   = 1'b1;
      end
      ST_IDLE: begin
        mem_addr = in_addr;
        if (start && in_item.action == ACT_WRITE) begin
          mem_we    = 1'b1;
          mem_wdata = {1'b0, in_item.spin_in};
        end else if (start && in_item.action == ACT_CLUSTER) begin
          fifo_we = 1'b1;
        end
      end
      ST_SEEDRD: begin
        mem_we    = 1'b1;
        mem_wdata = {1'b1, mem_q[0]};
      end
      ST_NBRRD: begin
        mem_addr = nbr;
      end
      ST_NBRTEST: begin
        mem_addr = nbr;
        rng_step = 1'b1;
        if (mem_q[0] == seed_spin && !mem_q[1] && draw_next < threshold
            && fifo_tail < (AW+1)'(NS)) begin
          mem_we    = 1'b1;
          mem_wdata = {1'b1, mem_q[0]};
          fifo_we   = 1'b1;
        end
      end
      ST_FLIPWR: begin
        mem_addr  = fifo_q;
        mem_we    = 1'b1;
        mem_wdata = {1'b0, ~mem_q[0]};
      end
      ST_FLIPRD: begin
        mem_addr = fifo_q;
      end
      ST_MSITE: begin
        // The site spin is read here and used in ST_MACC.
        mem_addr = count[AW-1:0];
      end
      ST_MNBR: begin
        mem_addr = nbr;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      count     <= '0;
      fifo_head <= '0;
      fifo_tail <= '0;
      dir       <= '0;
      done      <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        ST_CLEAR: begin
          count <= count + 1'b1;
          if (count == (AW+1)'(NS - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (start) begin
            act     <= in_item.action;
            cur     <= in_addr;
            wr_spin <= in_item.spin_in;
            res     <= '0;
            case (in_item.action)
              ACT_WRITE, ACT_READ: state <= ST_RW;
              ACT_CLUSTER: begin
                fifo_head <= '0;
                fifo_tail <= (AW+1)'(1);
                state     <= ST_SEEDRD;
              end
              default: begin
                count <= '0;
                ssum  <= '0;
                bsum  <= '0;
                state <= ST_MSITE;
              end
            endcase
          end
        end
        ST_RW: begin
          res.spin_out <= (act == ACT_WRITE) ? wr_spin : mem_q[0];
          state        <= ST_OUT;
        end
        ST_SEEDRD: begin
          seed_spin <= mem_q[0];
          state     <= ST_POP;
        end
        ST_POP: begin
          // fifo_q is read from fifo_head registered last cycle, which also
          // picks up an entry written by the last neighbor test.
          state <= ST_FIFORD;
        end
        ST_FIFORD: begin
          if (dir == 4'd15) begin
            state <= ST_FLIPRD;
          end else if (fifo_head == fifo_tail) begin
            // queue drained: start flip pass from entry zero
            fifo_head <= '0;
            dir       <= 4'd15;
          end else begin
            cur       <= fifo_q;
            dir       <= '0;
            fifo_head <= fifo_head + 1'b1;
            state     <= ST_NBRRD;
          end
        end
        ST_NBRRD: begin
          state <= ST_NBRTEST;
        end
        ST_NBRTEST: begin
          if (fifo_we) begin
            fifo_tail <= fifo_tail + 1'b1;
          end
          if (dir == 4'd9) begin
            state <= ST_POP;
          end else begin
            dir   <= dir + 1'b1;
            state <= ST_NBRRD;
          end
        end
        ST_FLIPRD: begin
          state <= ST_FLIPWR;
        end
        ST_FLIPWR: begin
          if (fifo_head + 1'b1 == fifo_tail) begin
            res.cluster_size <= 11'(fifo_tail);
            dir              <= '0;
            fifo_head        <= '0;
            fifo_tail        <= '0;
            state            <= ST_OUT;
          end else begin
            fifo_head <= fifo_head + 1'b1;
            state     <= ST_FIFORD;
          end
        end
        ST_MSITE: begin
          if (count == (AW+1)'(NS)) begin
            res.spin_sum <= ssum;
            res.bond_sum <= bsum;
            state        <= ST_OUT;
          end else if (!site_ok) begin
            count <= count + 1'b1;
          end else begin
            cur   <= count[AW-1:0];
            dir   <= '0;
            state <= ST_MACC;
          end
        end
        ST_MACC: begin
          // mem_q holds the site spin read at cur
          site_spin <= mem_q[0];
          ssum      <= mem_q[0] ? ssum + 12'sd1 : ssum - 12'sd1;
          state     <= ST_MNBR;
        end
        ST_MNBR: begin
          if (dir != 4'd0) begin
            bsum <= (mem_q[0] == site_spin) ? bsum - 15'sd1 : bsum + 15'sd1;
          end
          if (dir == 4'd10) begin
            count <= count + 1'b1;
            state <= ST_MSITE;
          end else begin
            dir <= dir + 1'b1;
          end
        end
        ST_OUT: begin
          done  <= 1'b1;
          state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // In ST_MNBR mem_q holds the read of neighbor dir-1, issued the cycle before;
  // dir 0 issues the first read and dir 10 consumes the last one.
  assign out_item = res;

  property p_done_pulse;
    @(posedge clk) disable iff (rst) done |=> !done;
  endproperty
  a_done_pulse: assert property (p_done_pulse) else $error("done held");

  property p_idle_after_done;
    @(posedge clk) disable iff (rst) done |-> !busy;
  endproperty
  a_idle_after_done: assert property (p_idle_after_done) else $error("busy on done");

  property p_fifo_order;
    @(posedge clk) disable iff (rst) state == ST_NBRTEST |-> fifo_head <= fifo_tail;
  endproperty
  a_fifo_order: assert property (p_fifo_order) else $error("queue overrun");

endmodule

// ----- rtl/wci5_rng.sv -----
// xorshift32 generator register for the Wolff unit.
// Depends on wci5_pkg.
module wci5_rng
  import wci5_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        load,
  input  logic [31:0] load_value,
  input  logic        step,
  output logic [15:0] draw_next
);

  logic [31:0] state;
  logic [31:0] stepped;

  assign stepped   = xorshift32(state);
  assign draw_next = stepped[31:16];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= 32'd1;
    end else if (load) begin
      state <= (load_value == 32'd0) ? 32'd1 : load_value;
    end else if (step) begin
      state <= stepped;
    end
  end

endmodule

// ----- rtl/wci5_nbr.sv -----
// Neighbor address unit: one of the ten periodic neighbors of a site.
// Depends on wci5_pkg.
module wci5_nbr
  import wci5_pkg::*;
#(
  parameter int SIDE = SIDE_DEF,
  localparam int CW = (SIDE > 1) ? $clog2(SIDE) : 1,
  localparam int AW = 5 * CW
) (
  input  logic [AW-1:0] site,
  input  logic [3:0]    dir,
  output logic [AW-1:0] nbr
);

  localparam logic [CW-1:0] TOP = CW'(SIDE - 1);

  logic [CW-1:0] c [5];
  logic [CW-1:0] n [5];
  logic [2:0]    dim;

  always_comb begin
    // coordinate 0 (x) is most significant
    for (int d = 0; d < 5; d++) begin
      c[d] = site[(4 - d) * CW +: CW];
    end
    dim = dir[3:1];
    for (int d = 0; d < 5; d++) begin
      n[d] = c[d];
      if (3'(d) == dim) begin
        if (!dir[0]) begin
          n[d] = (c[d] == TOP) ? '0 : c[d] + 1'b1;
        end else begin
          n[d] = (c[d] == '0) ? TOP : c[d] - 1'b1;
        end
      end
    end
    for (int d = 0; d < 5; d++) begin
      nbr[(4 - d) * CW +: CW] = n[d];
    end
  end

endmodule
